// ===== rtl/core/ile_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, operation and status codes, and sequencer states of the
// indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // stream field widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 5;
  localparam int VALUE_W   = 32;
  localparam int FIDX_W    = 4;
  localparam int REMOVED_W = 5;
  localparam int COUNT_W   = 5;
  localparam int STATUS_W  = 2;

  localparam int IN_FIELDS_W  = OP_W + POS_W + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + 1 + FIDX_W + REMOVED_W + COUNT_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 3'd0,
    OP_POP        = 3'd1,
    OP_INSERT     = 3'd2,
    OP_DELETE     = 3'd3,
    OP_FIND       = 3'd4,
    OP_REMOVE_ALL = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

endpackage

// ===== rtl/core/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered word list in a single-port-write, registered-read memory, driven by
// a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream (op, position, value); every request
//   gives exactly one response on the out_ stream (popped word, find result,
//   removed count, entry count after the request, status).
//   One request is worked on at a time; in_tready is high while the
//   sequencer is idle, also while a response still waits in the output
//   register.
//   Push, append, delete of the last entry, refused requests and
//   find/remove-all on an empty list go straight to the response; pop
//   waits for its read; insert moves the entries from position p up by one
//   place, top first; delete moves the entries above p down by one place;
//   find scans from index 0 up to the first hit, remove all every entry.
//   The walk reads at most one entry and writes at most one per cycle,
//   behind the registered read.
//   Reset clears the entry count and the handshake state; stored words are
//   not cleared. If out_tready stays low, a finished response waits in the
//   sequencer and no further request is taken until it is loaded.
// ----------------------------------------------------------------------------
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [2:0] op, [7:3] position, [39:8] value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] out_value, [32] found, [36:33] found_index, [41:37] removed_count,
  // [46:42] count, [48:47] status, [55:49] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [WORD_WIDTH-1:0] mem [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]      wr_idx_r, wr_idx_nxt;
  logic                  pend_r, pend_nxt;

  logic [VALUE_W-1:0]    res_value_r, res_value_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [FIDX_W-1:0]     res_index_r, res_index_nxt;
  logic [REMOVED_W-1:0]  res_removed_r, res_removed_nxt;
  status_t               res_status_r, res_status_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  op_t                   in_op;
  logic [POS_W-1:0]      in_pos;
  logic [WORD_WIDTH-1:0] in_word;
  logic [CNT_W-1:0]      rd_next;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W-1:0]      kept_final;
  logic                  full, empty;

  assign in_op   = op_t'(in_tdata[OP_W-1:0]);
  assign in_pos  = in_tdata[OP_W +: POS_W];
  assign in_word = in_tdata[OP_W + POS_W +: WORD_WIDTH];

  assign rd_next = {{(CNT_W-IDX_W){1'b0}}, rd_idx_r} + 1'b1;
  assign cnt_dec = cnt_r - 1'b1;
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign empty   = (cnt_r == '0);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // list store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    pos_r         <= pos_nxt;
    word_r        <= word_nxt;
    rd_idx_r      <= rd_idx_nxt;
    wr_idx_r      <= wr_idx_nxt;
    res_value_r   <= res_value_nxt;
    res_found_r   <= res_found_nxt;
    res_index_r   <= res_index_nxt;
    res_removed_r <= res_removed_nxt;
    res_status_r  <= res_status_nxt;
    out_data_r    <= out_data_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    pos_nxt         = pos_r;
    word_nxt        = word_r;
    cnt_nxt         = cnt_r;
    rd_idx_nxt      = rd_idx_r;
    wr_idx_nxt      = wr_idx_r;
    pend_nxt        = pend_r;
    res_value_nxt   = res_value_r;
    res_found_nxt   = res_found_r;
    res_index_nxt   = res_index_r;
    res_removed_nxt = res_removed_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_data_nxt    = out_data_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = word_r;
    mem_raddr       = '0;
    kept_final      = wr_idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt          = in_op;
          pos_nxt         = in_pos;
          word_nxt        = in_word;
          pend_nxt        = 1'b0;
          res_value_nxt   = '0;
          res_found_nxt   = 1'b0;
          res_index_nxt   = '0;
          res_removed_nxt = '0;
          res_status_nxt  = ST_OK;
          state_nxt       = S_FIN;
          case (in_op)
            OP_PUSH: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[IDX_W-1:0];
                mem_wdata = in_word;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_POP: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                mem_raddr = cnt_dec[IDX_W-1:0];
                cnt_nxt   = cnt_dec;
                pend_nxt  = 1'b1;
                state_nxt = S_RUN;
              end
            end
            OP_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else if (in_pos > cnt_r) begin
                res_status_nxt = ST_RANGE;
              end else if (in_pos == cnt_r) begin
                mem_we    = 1'b1;
                mem_waddr = cnt_r[IDX_W-1:0];
                mem_wdata = in_word;
                cnt_nxt   = cnt_r + 1'b1;
              end else begin
                // walk downward from the top entry, one move per cycle
                mem_raddr  = cnt_dec[IDX_W-1:0];
                rd_idx_nxt = cnt_dec[IDX_W-1:0];
                wr_idx_nxt = cnt_r;
                pend_nxt   = 1'b1;
                state_nxt  = S_RUN;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (in_pos >= cnt_r) begin
                res_status_nxt = ST_RANGE;
              end else if (in_pos == cnt_dec) begin
                cnt_nxt = cnt_dec;
              end else begin
                mem_raddr  = in_pos[IDX_W-1:0] + 1'b1;
                rd_idx_nxt = in_pos[IDX_W-1:0] + 1'b1;
                wr_idx_nxt = in_pos;
                pend_nxt   = 1'b1;
                state_nxt  = S_RUN;
              end
            end
            OP_FIND, OP_REMOVE_ALL: begin
              if (!empty) begin
                mem_raddr  = '0;
                rd_idx_nxt = '0;
                wr_idx_nxt = '0;
                pend_nxt   = 1'b1;
                state_nxt  = S_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        case (op_r)
          OP_POP: begin
            res_value_nxt = VALUE_W'(rd_data_r);
            pend_nxt      = 1'b0;
            state_nxt     = S_FIN;
          end
          OP_INSERT: begin
            if (pend_r) begin
              mem_we     = 1'b1;
              mem_waddr  = wr_idx_r[IDX_W-1:0];
              mem_wdata  = rd_data_r;
              wr_idx_nxt = wr_idx_r - 1'b1;
              if ({{(CNT_W-IDX_W){1'b0}}, rd_idx_r} > pos_r) begin
                mem_raddr  = rd_idx_r - 1'b1;
                rd_idx_nxt = rd_idx_r - 1'b1;
              end else begin
                pend_nxt = 1'b0;
              end
            end else begin
              // gap is open: drop the new word in
              mem_we    = 1'b1;
              mem_waddr = pos_r[IDX_W-1:0];
              mem_wdata = word_r;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_FIN;
            end
          end
          OP_DELETE: begin
            mem_we     = 1'b1;
            mem_waddr  = wr_idx_r[IDX_W-1:0];
            mem_wdata  = rd_data_r;
            wr_idx_nxt = wr_idx_r + 1'b1;
            if (rd_next < cnt_r) begin
              mem_raddr  = rd_next[IDX_W-1:0];
              rd_idx_nxt = rd_next[IDX_W-1:0];
            end else begin
              cnt_nxt   = cnt_dec;
              pend_nxt  = 1'b0;
              state_nxt = S_FIN;
            end
          end
          OP_FIND: begin
            if (rd_data_r == word_r) begin
              res_found_nxt = 1'b1;
              res_index_nxt = FIDX_W'(rd_idx_r);
              pend_nxt      = 1'b0;
              state_nxt     = S_FIN;
            end else if (rd_next < cnt_r) begin
              mem_raddr  = rd_next[IDX_W-1:0];
              rd_idx_nxt = rd_next[IDX_W-1:0];
            end else begin
              pend_nxt  = 1'b0;
              state_nxt = S_FIN;
            end
          end
          OP_REMOVE_ALL: begin
            // compaction: write pointer never passes the read pointer
            if (rd_data_r != word_r) begin
              mem_we     = 1'b1;
              mem_waddr  = wr_idx_r[IDX_W-1:0];
              mem_wdata  = rd_data_r;
              wr_idx_nxt = wr_idx_r + 1'b1;
              kept_final = wr_idx_r + 1'b1;
            end
            if (rd_next < cnt_r) begin
              mem_raddr  = rd_next[IDX_W-1:0];
              rd_idx_nxt = rd_next[IDX_W-1:0];
            end else begin
              res_removed_nxt = REMOVED_W'(cnt_r - kept_final);
              cnt_nxt         = kept_final;
              pend_nxt        = 1'b0;
              state_nxt       = S_FIN;
            end
          end
          default: begin
            pend_nxt  = 1'b0;
            state_nxt = S_FIN;
          end
        endcase
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, res_status_r, COUNT_W'(cnt_r),
                           res_removed_r, res_index_r, res_found_r, res_value_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/indexed_list_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_test
// Stream-level test of the indexed list engine. A shadow list in the bench
// predicts each response. Every response is checked against the oldest
// prediction. Directed requests cover the empty list, filling to capacity,
// the full list and search/remove. Random traffic then runs under three
// settings of sender and receiver stall rates, the last with no stalls.
// ----------------------------------------------------------------------------
module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 374;

  typedef struct packed {
    logic [VALUE_W-1:0]   word;
    logic                 hit;
    logic [FIDX_W-1:0]    hit_index;
    logic [REMOVED_W-1:0] removed;
    logic [COUNT_W-1:0]   count;
    status_t              status;
  } list_resp_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow copy of the list
  logic [VALUE_W-1:0] shadow_list [CAPACITY];
  int unsigned        shadow_len = 0;

  list_resp_t pending_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int error_count   = 0;
  int full_refusals = 0;
  int empty_refusals = 0;
  int cycle_count   = 0;

  indexed_list_engine u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] run stopped after %0d cycles, %0d responses outstanding",
               $time, cycle_count, pending_results.size());
      $display("indexed_list_engine: mismatch");
      $finish;
    end
  end

  // Applies one request to the shadow list and returns the response it gives.
  function automatic list_resp_t apply_request(logic [OP_W-1:0] op,
                                               logic [POS_W-1:0] pos,
                                               logic [VALUE_W-1:0] word);
    list_resp_t  r;
    int unsigned kept;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_list[IDX_W'(shadow_len)] = word;
          shadow_len++;
        end
      end
      OP_POP: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_len--;
          r.word = shadow_list[IDX_W'(shadow_len)];
        end
      end
      OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (int'(pos) > shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = shadow_len; i > int'(pos); i--)
            shadow_list[IDX_W'(i)] = shadow_list[IDX_W'(i-1)];
          shadow_list[pos[IDX_W-1:0]] = word;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= shadow_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = int'(pos); i + 1 < shadow_len; i++)
            shadow_list[IDX_W'(i)] = shadow_list[IDX_W'(i+1)];
          shadow_len--;
        end
      end
      OP_FIND: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (!r.hit && shadow_list[IDX_W'(i)] == word) begin
            r.hit       = 1'b1;
            r.hit_index = FIDX_W'(i);
          end
        end
      end
      OP_REMOVE_ALL: begin
        kept = 0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_list[IDX_W'(i)] != word) begin
            shadow_list[IDX_W'(kept)] = shadow_list[IDX_W'(i)];
            kept++;
          end
        end
        r.removed  = REMOVED_W'(shadow_len - kept);
        shadow_len = kept;
      end
      default: ;
    endcase
    r.count = COUNT_W'(shadow_len);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] word);
    list_resp_t resp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {word, pos, op};
    do @(posedge clk); while (!in_tready);
    resp = apply_request(op, pos, word);
    if (resp.status == ST_FULL) full_refusals++;
    if (resp.status == ST_EMPTY) empty_refusals++;
    pending_results.push_back(resp);
    sent_count++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_responses
    list_resp_t seen;
    list_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.word      = out_tdata[31:0];
      seen.hit       = out_tdata[32];
      seen.hit_index = out_tdata[36:33];
      seen.removed   = out_tdata[41:37];
      seen.count     = out_tdata[46:42];
      seen.status    = status_t'(out_tdata[48:47]);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("[%0t] response with nothing pending: %h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          error_count++;
          $display("[%0t] response %0d: expected word=%h hit=%0d idx=%0d rem=%0d cnt=%0d st=%0d",
                   $time, checked_count, want.word, want.hit, want.hit_index,
                   want.removed, want.count, want.status);
          $display("[%0t] response %0d: actual   word=%h hit=%0d idx=%0d rem=%0d cnt=%0d st=%0d",
                   $time, checked_count, seen.word, seen.hit, seen.hit_index,
                   seen.removed, seen.count, seen.status);
        end
      end
      checked_count++;
    end
  end

  // Mostly repeat-prone words so that find hits and remove-all matches happen.
  function automatic logic [VALUE_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30 && shadow_len > 0)
      return shadow_list[IDX_W'($urandom_range(0, shadow_len - 1))];
    if (r < 70) begin
      case ($urandom_range(0, 7))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h5A5A_5A5A;
        3: return 32'hA5A5_A5A5;
        4: return 32'h0000_0001;
        5: return 32'h8000_0000;
        6: return 32'h7FFF_FFFF;
        default: return 32'h1234_5678;
      endcase
    end
    return $urandom();
  endfunction

  task automatic test_empty_list();
    send_request(OP_POP, 5'd0, 32'hFFFF_FFFF);
    send_request(OP_DELETE, 5'd0, 32'h0);
    // unused op code: no change, only count reported
    send_request(3'd6, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_capacity();
    logic [VALUE_W-1:0] word;
    send_request(OP_INSERT, 5'd1, 32'hDEAD_BEEF);
    send_request(OP_INSERT, 5'd0, 32'hDEAD_BEEF);
    for (int i = 0; i < CAPACITY - 2; i++) begin
      case (i % 4)
        0: word = 32'h0000_0000;
        1: word = 32'hFFFF_FFFF;
        2: word = 32'h5A5A_5A5A;
        default: word = 32'hA5A5_0000 | i;
      endcase
      send_request(OP_PUSH, 5'd0, word);
    end
    // mid-list insert that makes the list full
    send_request(OP_INSERT, 5'd7, 32'h0F0F_0F0F);
  endtask

  task automatic test_full_list();
    send_request(OP_PUSH, 5'd0, 32'h1111_1111);
    send_request(OP_INSERT, 5'd0, 32'h2222_2222);
    // delete on a full list must still shift the tail down
    send_request(OP_DELETE, 5'd0, 32'h0);
    send_request(OP_DELETE, 5'd15, 32'h0);
  endtask

  task automatic test_search_and_remove();
    send_request(OP_FIND, 5'd0, 32'h5A5A_5A5A);
    send_request(OP_FIND, 5'd0, 32'h1234_5678);
    send_request(OP_REMOVE_ALL, 5'd0, 32'h0000_0000);
    send_request(OP_REMOVE_ALL, 5'd0, 32'h1234_5678);
    send_request(OP_POP, 5'd0, 32'h0);
  endtask

  task automatic test_random_traffic(int items, int send_pct, int recv_pct);
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] word;
    int unsigned        pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (items) begin
      pick = $urandom_range(0, 99);
      word = pick_word();
      pos  = POS_W'($urandom_range(0, 31));
      if (pick < 22) begin
        op = OP_PUSH;
      end else if (pick < 36) begin
        op = OP_POP;
      end else if (pick < 54) begin
        op = OP_INSERT;
        if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, shadow_len));
      end else if (pick < 68) begin
        op = OP_DELETE;
        if (shadow_len > 0 && $urandom_range(0, 9) != 0)
          pos = POS_W'($urandom_range(0, shadow_len - 1));
      end else if (pick < 82) begin
        op = OP_FIND;
      end else if (pick < 92) begin
        op = OP_REMOVE_ALL;
      end else if (pick < 96) begin
        op = OP_W'($urandom_range(6, 7));
      end else begin
        op = OP_W'($urandom_range(0, 7));
      end
      send_request(op, pos, word);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 7;
    recv_idle_pct = 65;
    test_empty_list();
    test_fill_to_capacity();
    test_full_list();
    test_search_and_remove();

    test_random_traffic(PHASE_ITEMS, 7, 65);
    test_random_traffic(PHASE_ITEMS, 65, 7);
    test_random_traffic(PHASE_ITEMS, 0, 0);
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      error_count++;
      $display("[%0t] %0d responses never arrived", $time, pending_results.size());
    end

    $display("%0d requests sent, %0d responses checked, %0d errors", sent_count,
             checked_count, error_count);
    $display("full-list refusals: %0d, empty-list refusals: %0d", full_refusals,
             empty_refusals);
    if (error_count == 0) begin
      $display("indexed_list_engine: match");
    end else begin
      $display("indexed_list_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ile_pkg.sv
rtl/core/indexed_list_engine.sv
tb/indexed_list_engine_test.sv
